[design/oled_text_glyph_renderer_defines.svh]
// Assertion macros shared by the glyph renderer modules.
`ifndef OLED_TEXT_GLYPH_RENDERER_DEFINES_SVH
`define OLED_TEXT_GLYPH_RENDERER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OTGR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OTGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/otgr_pkg.sv]
// Types, constants and the 5x7 font table of the glyph renderer.
`default_nettype none
package otgr_pkg;

    localparam int GLYPH_WIDTH = 5;
    localparam int NUM_PAGES   = 8;
    localparam int PAGE_W      = $clog2(NUM_PAGES);
    localparam int COL_W       = 8;
    localparam int IDX_W       = 7;
    localparam int STEP_W      = 4;

    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_FIRST     = 8'h20;
    localparam logic [7:0] CHAR_LAST      = 8'h7E;
    localparam logic [7:0] GLYPH_ADVANCE  = 8'(GLYPH_WIDTH + 1);

    // Controller command prefixes
    localparam logic [7:0] CMD_PAGE   = 8'hB0;
    localparam logic [3:0] CMD_COL_LO = 4'h0;
    localparam logic [3:0] CMD_COL_HI = 4'h1;

    // Byte positions inside one job's run
    localparam logic [STEP_W-1:0] STEP_PAGE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_COL_LO = 4'd1;
    localparam logic [STEP_W-1:0] STEP_COL_HI = 4'd2;
    localparam logic [STEP_W-1:0] STEP_GLYPH  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_BLANK  = 4'(3 + GLYPH_WIDTH);

    // One classified item, handed from front to back
    typedef struct packed {
        logic              has_cursor;
        logic [PAGE_W-1:0] page;
        logic [COL_W-1:0]  column;
        logic              has_glyph;
        logic [IDX_W-1:0]  glyph_idx;
    } job_t;

    // Font lookup: glyph words hold column 0 in the top byte
    function automatic logic [7:0] glyph_column(input logic [IDX_W-1:0] idx,
                                                input logic [2:0] k);
        logic [39:0] g;
        logic [7:0]  c;
        case (idx)
            7'd0:  g = 40'h0000000000;
            7'd1:  g = 40'h00002f0000;
            7'd2:  g = 40'h0007000700;
            7'd3:  g = 40'h147f147f14;
            7'd4:  g = 40'h242a7f2a12;
            7'd5:  g = 40'h2313086462;
            7'd6:  g = 40'h3649552250;
            7'd7:  g = 40'h0005030000;
            7'd8:  g = 40'h001c224100;
            7'd9:  g = 40'h0041221c00;
            7'd10: g = 40'h14083E0814;
            7'd11: g = 40'h08083E0808;
            7'd12: g = 40'h0000A06000;
            7'd13: g = 40'h0808080808;
            7'd14: g = 40'h0060600000;
            7'd15: g = 40'h2010080402;
            7'd16: g = 40'h3E5149453E;
            7'd17: g = 40'h00427F4000;
            7'd18: g = 40'h4261514946;
            7'd19: g = 40'h2141454B31;
            7'd20: g = 40'h1814127F10;
            7'd21: g = 40'h2745454539;
            7'd22: g = 40'h3C4A494930;
            7'd23: g = 40'h0171090503;
            7'd24: g = 40'h3649494936;
            7'd25: g = 40'h064949291E;
            7'd26: g = 40'h0036360000;
            7'd27: g = 40'h0056360000;
            7'd28: g = 40'h0814224100;
            7'd29: g = 40'h1414141414;
            7'd30: g = 40'h0041221408;
            7'd31: g = 40'h0201510906;
            7'd32: g = 40'h324959513E;
            7'd33: g = 40'h7C1211127C;
            7'd34: g = 40'h7F49494936;
            7'd35: g = 40'h3E41414122;
            7'd36: g = 40'h7F4141221C;
            7'd37: g = 40'h7F49494941;
            7'd38: g = 40'h7F09090901;
            7'd39: g = 40'h3E4149497A;
            7'd40: g = 40'h7F0808087F;
            7'd41: g = 40'h00417F4100;
            7'd42: g = 40'h2040413F01;
            7'd43: g = 40'h7F08142241;
            7'd44: g = 40'h7F40404040;
            7'd45: g = 40'h7F020C027F;
            7'd46: g = 40'h7F0408107F;
            7'd47: g = 40'h3E4141413E;
            7'd48: g = 40'h7F09090906;
            7'd49: g = 40'h3E4151215E;
            7'd50: g = 40'h7F09192946;
            7'd51: g = 40'h4649494931;
            7'd52: g = 40'h01017F0101;
            7'd53: g = 40'h3F4040403F;
            7'd54: g = 40'h1F2040201F;
            7'd55: g = 40'h3F4038403F;
            7'd56: g = 40'h6314081463;
            7'd57: g = 40'h0708700807;
            7'd58: g = 40'h6151494543;
            7'd59: g = 40'h007F414100;
            7'd60: g = 40'h55AA55AA55;
            7'd61: g = 40'h0041417F00;
            7'd62: g = 40'h0402010204;
            7'd63: g = 40'h4040404040;
            7'd64: g = 40'h0003050000;
            7'd65: g = 40'h2054545478;
            7'd66: g = 40'h7F48444438;
            7'd67: g = 40'h3844444420;
            7'd68: g = 40'h384444487F;
            7'd69: g = 40'h3854545418;
            7'd70: g = 40'h087E090102;
            7'd71: g = 40'h18A4A4A47C;
            7'd72: g = 40'h7F08040478;
            7'd73: g = 40'h00447D4000;
            7'd74: g = 40'h4080847D00;
            7'd75: g = 40'h7F10284400;
            7'd76: g = 40'h00417F4000;
            7'd77: g = 40'h7C04180478;
            7'd78: g = 40'h7C08040478;
            7'd79: g = 40'h3844444438;
            7'd80: g = 40'hFC24242418;
            7'd81: g = 40'h18242418FC;
            7'd82: g = 40'h7C08040408;
            7'd83: g = 40'h4854545420;
            7'd84: g = 40'h043F444020;
            7'd85: g = 40'h3C4040207C;
            7'd86: g = 40'h1C2040201C;
            7'd87: g = 40'h3C4030403C;
            7'd88: g = 40'h4428102844;
            7'd89: g = 40'h1CA0A0A07C;
            7'd90: g = 40'h4464544C44;
            7'd91: g = 40'h00107C8200;
            7'd92: g = 40'h0000FF0000;
            7'd93: g = 40'h00827C1000;
            7'd94: g = 40'h0006090906;
            default: g = 40'h0000000000;
        endcase
        case (k)
            3'd0:    c = g[39:32];
            3'd1:    c = g[31:24];
            3'd2:    c = g[23:16];
            3'd3:    c = g[15:8];
            3'd4:    c = g[7:0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

[design/otgr_front.sv]
// Front end: accepts items, keeps the cursor and classifies each item into a job.
`default_nettype none
module otgr_front #(
    parameter int NUM_COLUMNS = 132
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [23:0]   s_tdata,   // char_code[7:0], page_line[11:8], column[19:12]
    input  wire logic          s_tuser,   // func
    input  wire logic          queue_full,
    output logic               push,
    output otgr_pkg::job_t     job
);

    logic [otgr_pkg::PAGE_W-1:0] page_reg, page_next;
    logic [otgr_pkg::COL_W-1:0]  column_reg, column_next;

    logic [7:0]                  char_code;
    logic [3:0]                  page_line;
    logic [7:0]                  column;
    logic                        accept;
    logic                        set_ok;
    logic                        newline;
    logic                        wrap;
    logic                        printable;
    logic [otgr_pkg::COL_W-1:0]  base_col;

    assign char_code = s_tdata[7:0];
    assign page_line = s_tdata[11:8];
    assign column    = s_tdata[19:12];

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    // Classify the incoming transfer
    assign set_ok    = (page_line < 4'(otgr_pkg::NUM_PAGES))
                       && ({1'b0, column} < 9'(NUM_COLUMNS));
    assign newline   = (char_code == otgr_pkg::CHAR_NEWLINE);
    assign wrap      = ({1'b0, column_reg} + 9'(otgr_pkg::GLYPH_WIDTH)) >= 9'(NUM_COLUMNS);
    assign printable = (char_code >= otgr_pkg::CHAR_FIRST)
                       && (char_code <= otgr_pkg::CHAR_LAST);
    assign base_col  = (wrap || newline) ? '0 : column_reg;

    // Build the job and the next cursor
    always_comb
    begin
        job         = '0;
        page_next   = page_reg;
        column_next = column_reg;
        if (s_tuser)
        begin
            job.has_cursor = 1'b1;
            job.page       = page_line[otgr_pkg::PAGE_W-1:0];
            job.column     = column;
            if (set_ok)
            begin
                page_next   = page_line[otgr_pkg::PAGE_W-1:0];
                column_next = column;
            end
        end
        else
        begin
            job.has_cursor = wrap || newline;
            job.page       = page_reg + 1'b1;
            job.column     = '0;
            job.has_glyph  = !newline;
            job.glyph_idx  = printable ? 7'(char_code - otgr_pkg::CHAR_FIRST) : '0;
            if (wrap || newline)
            begin
                page_next = page_reg + 1'b1;
            end
            column_next = newline ? '0 : (base_col + otgr_pkg::GLYPH_ADVANCE);
        end
    end

    // Drop out-of-range cursor requests
    assign push = accept && (!s_tuser || set_ok);

    // Hold the cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg   <= '0;
            column_reg <= '0;
        end
        else if (accept)
        begin
            page_reg   <= page_next;
            column_reg <= column_next;
        end
    end

endmodule
`default_nettype wire

[design/otgr_queue.sv]
// Two-entry job queue between front end and byte sequencer.
`default_nettype none
`include "oled_text_glyph_renderer_defines.svh"
module otgr_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire otgr_pkg::job_t   push_job,
    input  wire logic             pop,
    output logic                  full,
    output logic                  head_valid,
    output otgr_pkg::job_t        head
);

    otgr_pkg::job_t entries_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entries_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    `OTGR_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !full || pop, "push into full queue")
    `OTGR_ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, head_valid, "pop from empty queue")
    `OTGR_ASSERT_IMPLY(a_count_range, clk, rst_n, 1'b1, count_reg != 2'd3, "queue count out of range")
    `OTGR_ASSERT_NEXT(a_ptr_track, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 2'd1,
        "queue count lost a push")

endmodule
`default_nettype wire

[design/otgr_back.sv]
// Back end: walks each job byte by byte and drives the registered output.
`default_nettype none
`include "oled_text_glyph_renderer_defines.svh"
module otgr_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             head_valid,
    input  wire otgr_pkg::job_t   head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,   // out_byte
    output logic                  m_tuser,   // is_command
    output logic                  m_tlast    // last
);

    logic [otgr_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        started_reg, started_next;
    logic                        valid_reg, valid_next;
    logic [7:0]                  byte_reg;
    logic                        cmd_reg;
    logic                        last_reg;

    logic [otgr_pkg::STEP_W-1:0] cur_step;
    logic [otgr_pkg::STEP_W-1:0] end_step;
    logic [2:0]                  glyph_k;
    logic                        load;
    logic                        at_end;
    logic [7:0]                  byte_val;
    logic                        cmd_val;

    // Pick the byte position within the current job
    assign cur_step = started_reg ? step_reg
                      : (head.has_cursor ? otgr_pkg::STEP_PAGE : otgr_pkg::STEP_GLYPH);
    assign end_step = head.has_glyph ? otgr_pkg::STEP_BLANK : otgr_pkg::STEP_COL_HI;
    assign at_end   = (cur_step == end_step);
    assign glyph_k  = 3'(cur_step - otgr_pkg::STEP_GLYPH);

    // Output register takes a byte when empty or being drained
    assign load = head_valid && (!valid_reg || m_tready);
    assign pop  = load && at_end;

    // Form the byte for this position
    always_comb
    begin
        cmd_val = 1'b0;
        case (cur_step)
            otgr_pkg::STEP_PAGE:
            begin
                byte_val = otgr_pkg::CMD_PAGE | 8'(head.page);
                cmd_val  = 1'b1;
            end
            otgr_pkg::STEP_COL_LO:
            begin
                byte_val = {otgr_pkg::CMD_COL_LO, head.column[3:0]};
                cmd_val  = 1'b1;
            end
            otgr_pkg::STEP_COL_HI:
            begin
                byte_val = {otgr_pkg::CMD_COL_HI, head.column[7:4]};
                cmd_val  = 1'b1;
            end
            otgr_pkg::STEP_BLANK:
            begin
                byte_val = 8'h00;
            end
            default:
            begin
                byte_val = otgr_pkg::glyph_column(head.glyph_idx, glyph_k);
            end
        endcase
    end

    // Advance the step counter
    always_comb
    begin
        step_next    = step_reg;
        started_next = started_reg;
        valid_next   = valid_reg;
        if (load)
        begin
            valid_next   = 1'b1;
            started_next = !at_end;
            step_next    = cur_step + 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= '0;
            started_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            started_reg <= started_next;
            valid_reg   <= valid_next;
        end
    end

    // Hold the output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_val;
            cmd_reg  <= cmd_val;
            last_reg <= at_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = cmd_reg;
    assign m_tlast  = last_reg;

    `OTGR_ASSERT_NEXT(a_pop_marks_last, clk, rst_n, pop, m_tvalid && m_tlast,
        "job retired without last byte")
    `OTGR_ASSERT_IMPLY(a_started_has_job, clk, rst_n, started_reg, head_valid,
        "sequencer mid-job with empty queue")
    `OTGR_ASSERT_IMPLY(a_step_range, clk, rst_n, head_valid, cur_step <= otgr_pkg::STEP_BLANK,
        "byte position past end of run")
    `OTGR_ASSERT_NEXT(a_last_not_cmd_glyph, clk, rst_n, load && head.has_glyph && at_end,
        !m_tuser && (m_tdata == 8'h00), "glyph run must end on blank data column")

endmodule
`default_nettype wire

[design/oled_text_glyph_renderer.sv]
// Top level of the text glyph renderer for a page-addressed OLED controller.
// Each input transfer is a character to print (tuser low) or a set-cursor request
// (tuser high); the block answers with a run of controller bytes on the output
// stream, tuser high for command bytes, tlast on the final byte of each run. A
// printed character gives six data bytes, preceded by page, low-column and
// high-column commands when it wraps; a newline gives just those three commands; a
// valid set-cursor gives the three commands, an out-of-range one gives nothing.
// The output carries one byte per clock while the receiver is ready, and an item
// causes 3 to 9 bytes, all sent by the byte sequencer in turn; the front end takes
// a new input every cycle while its two-entry job queue has room. On an empty path,
// an item passes the job queue, then the output register, before its first byte shows.
`default_nettype none
module oled_text_glyph_renderer #(
    parameter int NUM_COLUMNS = 132
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // char_code[7:0], page_line[11:8], column[19:12]
    input  wire logic        s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte[7:0]
    output logic             m_tuser,   // is_command
    output logic             m_tlast    // last
);

    otgr_pkg::job_t push_job;
    otgr_pkg::job_t head;
    logic           push;
    logic           pop;
    logic           full;
    logic           head_valid;

    otgr_front #(
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (full),
        .push       (push),
        .job        (push_job)
    );

    otgr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    otgr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
`default_nettype wire

[sim/otgr_tb_pkg.sv]
// Item codes shared by the glyph renderer testbench modules.
package otgr_tb_pkg;

    // Operation carried on the input tuser bit
    localparam logic FUNC_PRINT  = 1'b0;
    localparam logic FUNC_CURSOR = 1'b1;

endpackage

[sim/otgr_byte_stream_checker.sv]
// Predicts the controller byte stream of the glyph renderer and checks each output transfer.
module otgr_byte_stream_checker #(
    parameter int NUM_COLUMNS = 132
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,   // char_code[7:0], page_line[11:8], column[19:12]
    input  wire logic        s_tuser,   // func
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,   // out_byte[7:0]
    input  wire logic        m_tuser,   // is_command
    input  wire logic        m_tlast,   // last
    output int               fail_count,
    output int               pending_count
);

    typedef struct packed {
        logic [7:0] data;
        logic       cmd;
        logic       last;
    } ctrl_byte_t;

    // 5x7 font, codes 0x20..0x7E; leftmost glyph column in the top byte
    localparam logic [39:0] FONT_WORDS [95] = '{
        40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
        40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
        40'h14083E0814, 40'h08083E0808, 40'h0000A06000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
        40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324959513E, 40'h7C1211127C, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
        40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h55AA55AA55, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0003050000,
        40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
        40'h087E090102, 40'h18A4A4A47C, 40'h7F08040478, 40'h00447D4000, 40'h4080847D00,
        40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'hFC24242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
        40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h1CA0A0A07C,
        40'h4464544C44, 40'h00107C8200, 40'h0000FF0000, 40'h00827C1000, 40'h0006090906
    };

    ctrl_byte_t  expected_bytes[$];
    ctrl_byte_t  run_buf[9];
    int          run_len;
    logic [2:0]  cursor_page;
    logic [7:0]  cursor_column;

    task automatic add_byte(input logic [7:0] data, input logic cmd);
        run_buf[run_len] = '{data: data, cmd: cmd, last: 1'b0};
        run_len++;
    endtask

    // Page, low-column and high-column commands for one cursor position
    task automatic add_cursor(input logic [2:0] page, input logic [7:0] col);
        add_byte(otgr_pkg::CMD_PAGE | {5'b0, page}, 1'b1);
        add_byte({otgr_pkg::CMD_COL_LO, col[3:0]}, 1'b1);
        add_byte({otgr_pkg::CMD_COL_HI, col[7:4]}, 1'b1);
    endtask

    // Work out the bytes caused by one input item and queue them
    task automatic render_item(input logic func, input logic [7:0] code,
                               input logic [3:0] page, input logic [7:0] col);
        logic [6:0]  idx;
        logic [39:0] glyph;
        run_len = 0;
        if (func == otgr_tb_pkg::FUNC_CURSOR)
        begin
            // Out-of-range positions are dropped silently
            if (int'(page) < otgr_pkg::NUM_PAGES && int'(col) < NUM_COLUMNS)
            begin
                cursor_page   = page[2:0];
                cursor_column = col;
                add_cursor(cursor_page, cursor_column);
            end
        end
        else
        begin
            // Wrap to the next page on overflow or newline, once for both
            if (int'(cursor_column) + otgr_pkg::GLYPH_WIDTH >= NUM_COLUMNS
                || code == otgr_pkg::CHAR_NEWLINE)
            begin
                cursor_page   = cursor_page + 3'd1;
                cursor_column = 8'd0;
                add_cursor(cursor_page, cursor_column);
            end
            if (code != otgr_pkg::CHAR_NEWLINE)
            begin
                // Unprintable codes draw the blank glyph
                idx   = (code >= otgr_pkg::CHAR_FIRST && code <= otgr_pkg::CHAR_LAST)
                        ? 7'(code - otgr_pkg::CHAR_FIRST) : 7'd0;
                glyph = FONT_WORDS[idx];
                for (int k = 0; k < otgr_pkg::GLYPH_WIDTH; k++)
                    add_byte(glyph[39 - 8 * k -: 8], 1'b0);
                add_byte(8'h00, 1'b0);
                cursor_column = cursor_column + 8'(otgr_pkg::GLYPH_WIDTH + 1);
            end
        end
        for (int k = 0; k < run_len; k++)
        begin
            if (k == run_len - 1)
                run_buf[k].last = 1'b1;
            expected_bytes.push_back(run_buf[k]);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] expv, input logic [7:0] actv);
        if (expv !== actv)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, actv);
            fail_count++;
        end
    endtask

    // Compare output transfers first, then predict from the input transfer
    always @(posedge clk or negedge rst_n)
    begin
        ctrl_byte_t exp_byte;
        if (!rst_n)
        begin
            cursor_page   = '0;
            cursor_column = '0;
            expected_bytes.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected output transfer, expected none, %s %h cmd %b last %b",
                             $time, "actual", m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end
                else
                begin
                    exp_byte = expected_bytes.pop_front();
                    check_field("out_byte", exp_byte.data, m_tdata);
                    check_field("is_command", {7'b0, exp_byte.cmd}, {7'b0, m_tuser});
                    check_field("last", {7'b0, exp_byte.last}, {7'b0, m_tlast});
                end
            end
            if (s_tvalid && s_tready)
                render_item(s_tuser, s_tdata[7:0], s_tdata[11:8], s_tdata[19:12]);
            pending_count = expected_bytes.size();
        end
    end

endmodule

[sim/oled_text_glyph_renderer_tb.sv]
// Stimulus and verdict for the text glyph renderer, checked by a stream checker beside it.
module oled_text_glyph_renderer_tb;

    localparam int NUM_COLUMNS  = 132;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 70;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int fail_count;
    int pending_count;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;

    always #1 clk = ~clk;

    oled_text_glyph_renderer #(
        .NUM_COLUMNS(NUM_COLUMNS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    otgr_byte_stream_checker #(
        .NUM_COLUMNS(NUM_COLUMNS)
    ) byte_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Stall the output side at random
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Present one item, idle first at random, and hold it until the transfer
    task automatic send_item(input logic func, input logic [7:0] code,
                             input logic [3:0] page, input logic [7:0] col);
        logic accepted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {4'b0, col, page, code};
        // Sample ready mid-cycle; it only changes after a rising edge
        do
        begin
            @(negedge clk);
            accepted = s_tready;
            @(posedge clk);
        end
        while (!accepted);
    endtask

    // Unused fields carry random bits
    task automatic send_print(input logic [7:0] code);
        send_item(otgr_tb_pkg::FUNC_PRINT, code, 4'($urandom_range(0, 15)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic send_cursor(input logic [3:0] page, input logic [7:0] col);
        send_item(otgr_tb_pkg::FUNC_CURSOR, 8'($urandom_range(0, 255)), page, col);
    endtask

    // Mostly printable text, with newlines, odd codes and cursor moves mixed in
    task automatic send_random_item();
        int          pick;
        logic [7:0]  code;
        pick = $urandom_range(0, 99);
        if (pick < 62)
            send_print(8'($urandom_range(otgr_pkg::CHAR_FIRST, otgr_pkg::CHAR_LAST)));
        else if (pick < 72)
            send_print(otgr_pkg::CHAR_NEWLINE);
        else if (pick < 78)
        begin
            code = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31))
                                               : 8'($urandom_range(127, 255));
            if (code == otgr_pkg::CHAR_NEWLINE)
                code = 8'h0B;
            send_print(code);
        end
        else if (pick < 90)
            send_cursor(4'($urandom_range(0, otgr_pkg::NUM_PAGES - 1)),
                        8'($urandom_range(0, NUM_COLUMNS - 1)));
        else if ($urandom_range(0, 1) == 0)
            send_cursor(4'($urandom_range(otgr_pkg::NUM_PAGES, 15)), 8'($urandom_range(0, 255)));
        else
            send_cursor(4'($urandom_range(0, 15)), 8'($urandom_range(NUM_COLUMNS, 255)));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, blank glyph codes, wraps and rejected cursors
        send_cursor(4'd0, 8'd0);
        send_print(otgr_pkg::CHAR_FIRST);
        send_print(8'h41);
        send_print(otgr_pkg::CHAR_LAST);
        send_print(8'h7F);
        send_print(8'hFF);
        send_print(8'h00);
        send_print(8'h1F);
        send_print(otgr_pkg::CHAR_NEWLINE);
        send_cursor(4'd7, 8'(NUM_COLUMNS - 1));
        send_print(8'h5A);
        send_cursor(4'd8, 8'd0);
        send_cursor(4'd15, 8'd255);
        send_cursor(4'd0, 8'(NUM_COLUMNS));
        send_cursor(4'd2, 8'(NUM_COLUMNS - 6));
        send_print(8'h60);
        send_print(8'h40);
        send_cursor(4'd4, 8'(NUM_COLUMNS - 3));
        send_print(otgr_pkg::CHAR_NEWLINE);
        send_cursor(4'd7, 8'd10);
        send_print(otgr_pkg::CHAR_NEWLINE);
        send_print(8'h7D);

        // Random: no idling, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 59 : (phase == 3) ? 17 : 0;
            stall_pct     = (phase == 2) ? 59 : (phase == 3) ? 17 : 0;
            repeat (PHASE_ITEMS) send_random_item();
        end
        s_tvalid <= 1'b0;

        // Drain the remaining output
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
